// ===== design/hnsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hnsf_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int HASH_W          = 64;
    localparam int CHAR_W          = 8;
    localparam int CODE_W          = 2;
    localparam int OUT_DATA_W      = 72;

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam int                HASH_SHIFT = 5;

    typedef enum logic [CODE_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [CODE_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [CODE_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_DUP  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_EMIT   = 2'd2
    } t_state;

    // Search token handed from cell to cell: tok marks the probe, hit
    // collects the matches seen so far.
    typedef struct packed {
        logic tok;
        logic hit;
    } t_probe;

endpackage

`default_nettype wire

// ===== design/hnsf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnsf_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hnsf_pkg::t_probe            i_probe,
    output hnsf_pkg::t_probe                 o_probe,
    input  wire logic [hnsf_pkg::HASH_W-1:0] i_key,
    input  wire logic [CNT_W-1:0]            i_count,
    input  wire logic                        i_wr_en
);

    logic [hnsf_pkg::HASH_W-1:0] r_entry;
    hnsf_pkg::t_probe            r_probe;
    hnsf_pkg::t_probe            n_probe;
    logic                        w_live;
    logic                        w_wr;

    // An entry counts only once it lies below the fill count.
    assign w_live = CNT_W'(INDEX) < i_count;
    assign w_wr   = i_wr_en && (i_count == CNT_W'(INDEX));

    always_comb begin
        n_probe.tok = i_probe.tok;
        n_probe.hit = i_probe.hit || (i_probe.tok && w_live && (r_entry == i_key));
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== design/hnsf_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnsf_chain #(
    parameter int TABLE_DEPTH = hnsf_pkg::TABLE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [hnsf_pkg::HASH_W-1:0] i_key,
    input  wire logic [CNT_W-1:0]            i_count,
    input  wire logic                        i_wr_en,
    output logic                             o_done,
    output logic                             o_hit
);

    hnsf_pkg::t_probe w_probe [TABLE_DEPTH+1];

    always_comb begin
        w_probe[0].tok = i_start;
        w_probe[0].hit = 1'b0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        hnsf_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1]),
            .i_key   (i_key),
            .i_count (i_count),
            .i_wr_en (i_wr_en)
        );
    end

    assign o_done = w_probe[TABLE_DEPTH].tok;
    assign o_hit  = w_probe[TABLE_DEPTH].hit;

endmodule

`default_nettype wire

// ===== design/hashed_name_set_filter_core.sv =====
`timescale 1ns / 1ps
// A character that does not end a name is taken while idle. A clear reply moves
// from the pending to the output registers; an end-of-name reply takes the same
// path once the probe has walked the row of cells. Throughput: one beat per cycle
// within a name; after a name end or a clear, input waits until its reply loads.
// Reset (synchronous, active low) empties the set, reseeds the hash and clears mode.
`default_nettype none

module hashed_name_set_filter_core #(
    parameter int TABLE_DEPTH = hnsf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata,   // exclude_mode
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [hnsf_pkg::CHAR_W-1:0]     s_axis_tdata,  // [7:0] character
    input  wire logic [hnsf_pkg::CODE_W-1:0]     s_axis_tuser,  // [1:0] action
    input  wire logic                            s_axis_tlast,  // last
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [1:0] status, [2] found, [3] filtered, [67:4] name_hash, [71:68] zero
    output logic [hnsf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [hnsf_pkg::CODE_W-1:0]          m_axis_tuser   // [1:0] reply_kind
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PAD_W = hnsf_pkg::OUT_DATA_W - hnsf_pkg::HASH_W - 4;

    hnsf_pkg::t_state             r_state, n_state;
    logic [hnsf_pkg::HASH_W-1:0]  r_hash, n_hash;
    logic [hnsf_pkg::HASH_W-1:0]  r_key, n_key;
    hnsf_pkg::t_kind              r_kind, n_kind;
    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_mode;
    logic                         r_start, n_start;

    hnsf_pkg::t_kind              r_pend_kind, n_pend_kind;
    hnsf_pkg::t_status            r_pend_status, n_pend_status;
    logic                         r_pend_found, n_pend_found;
    logic                         r_pend_filtered, n_pend_filtered;
    logic [hnsf_pkg::HASH_W-1:0]  r_pend_hash, n_pend_hash;

    logic                         r_out_valid, n_out_valid;
    hnsf_pkg::t_kind              r_out_kind;
    hnsf_pkg::t_status            r_out_status;
    logic                         r_out_found;
    logic                         r_out_filtered;
    logic [hnsf_pkg::HASH_W-1:0]  r_out_hash;

    logic                         w_fire;
    logic                         w_load;
    logic                         w_done;
    logic                         w_hit;
    logic                         w_full;
    logic                         w_wr_en;
    logic [hnsf_pkg::HASH_W-1:0]  w_hash_step;
    hnsf_pkg::t_action            w_action;

    assign w_action    = hnsf_pkg::t_action'(s_axis_tuser);
    assign w_fire      = s_axis_tvalid && s_axis_tready;
    assign w_hash_step = (r_hash << hnsf_pkg::HASH_SHIFT) + r_hash
                         + {{(hnsf_pkg::HASH_W - hnsf_pkg::CHAR_W){1'b0}}, s_axis_tdata};
    assign w_full      = r_count == CNT_W'(TABLE_DEPTH);
    assign w_load      = (r_state == hnsf_pkg::S_EMIT) && (!r_out_valid || m_axis_tready);
    assign w_wr_en     = (r_state == hnsf_pkg::S_SEARCH) && w_done
                         && (r_kind == hnsf_pkg::KIND_INSERT) && !w_full && !w_hit;

    hnsf_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_key   (r_key),
        .i_count (r_count),
        .i_wr_en (w_wr_en),
        .o_done  (w_done),
        .o_hit   (w_hit)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hnsf_pkg::S_IDLE: begin
                if (w_fire) begin
                    unique case (w_action)
                        hnsf_pkg::ACT_CLEAR: n_state = hnsf_pkg::S_EMIT;
                        hnsf_pkg::ACT_INSERT,
                        hnsf_pkg::ACT_QUERY: begin
                            if (s_axis_tlast) begin
                                n_state = hnsf_pkg::S_SEARCH;
                            end
                        end
                        default: n_state = hnsf_pkg::S_IDLE;
                    endcase
                end
            end
            hnsf_pkg::S_SEARCH: begin
                if (w_done) begin
                    n_state = hnsf_pkg::S_EMIT;
                end
            end
            hnsf_pkg::S_EMIT: begin
                if (w_load) begin
                    n_state = hnsf_pkg::S_IDLE;
                end
            end
            default: n_state = hnsf_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        s_axis_tready   = r_state == hnsf_pkg::S_IDLE;
        n_hash          = r_hash;
        n_key           = r_key;
        n_kind          = r_kind;
        n_count         = r_count;
        n_start         = 1'b0;
        n_pend_kind     = r_pend_kind;
        n_pend_status   = r_pend_status;
        n_pend_found    = r_pend_found;
        n_pend_filtered = r_pend_filtered;
        n_pend_hash     = r_pend_hash;
        n_out_valid     = r_out_valid;

        unique case (r_state)
            hnsf_pkg::S_IDLE: begin
                if (w_fire) begin
                    unique case (w_action)
                        hnsf_pkg::ACT_CLEAR: begin
                            n_hash          = hnsf_pkg::HASH_SEED;
                            n_count         = '0;
                            n_pend_kind     = hnsf_pkg::KIND_CLEAR;
                            n_pend_status   = hnsf_pkg::STAT_OK;
                            n_pend_found    = 1'b0;
                            n_pend_filtered = 1'b0;
                            n_pend_hash     = '0;
                        end
                        hnsf_pkg::ACT_INSERT,
                        hnsf_pkg::ACT_QUERY: begin
                            if (s_axis_tlast) begin
                                n_hash  = hnsf_pkg::HASH_SEED;
                                n_key   = w_hash_step;
                                n_start = 1'b1;
                                n_kind  = (w_action == hnsf_pkg::ACT_INSERT)
                                          ? hnsf_pkg::KIND_INSERT : hnsf_pkg::KIND_QUERY;
                            end else begin
                                n_hash = w_hash_step;
                            end
                        end
                        default: n_hash = r_hash;
                    endcase
                end
            end
            hnsf_pkg::S_SEARCH: begin
                if (w_done) begin
                    n_pend_kind  = r_kind;
                    n_pend_found = w_hit;
                    n_pend_hash  = r_key;
                    if (r_kind == hnsf_pkg::KIND_INSERT) begin
                        n_pend_filtered = 1'b0;
                        priority if (w_full) begin
                            n_pend_status = hnsf_pkg::STAT_FULL;
                        end else if (w_hit) begin
                            n_pend_status = hnsf_pkg::STAT_DUP;
                        end else begin
                            n_pend_status = hnsf_pkg::STAT_OK;
                            n_count       = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_pend_status   = hnsf_pkg::STAT_OK;
                        n_pend_filtered = w_hit == r_mode;
                    end
                end
            end
            default: n_hash = r_hash;
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hnsf_pkg::S_IDLE;
            r_hash      <= hnsf_pkg::HASH_SEED;
            r_count     <= '0;
            r_mode      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_count     <= n_count;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key           <= n_key;
        r_kind          <= n_kind;
        r_pend_kind     <= n_pend_kind;
        r_pend_status   <= n_pend_status;
        r_pend_found    <= n_pend_found;
        r_pend_filtered <= n_pend_filtered;
        r_pend_hash     <= n_pend_hash;
        if (w_load) begin
            r_out_kind     <= r_pend_kind;
            r_out_status   <= r_pend_status;
            r_out_found    <= r_pend_found;
            r_out_filtered <= r_pend_filtered;
            r_out_hash     <= r_pend_hash;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_hash, r_out_filtered, r_out_found,
                            r_out_status};

endmodule

`default_nettype wire

// ===== design/hnsf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnsf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [hnsf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [hnsf_pkg::CODE_W-1:0]     m_axis_tuser
);

    // A stalled reply beat must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("reply beat changed while stalled");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == hnsf_pkg::KIND_CLEAR) |-> m_axis_tdata == '0)
        else $error("clear reply carries non-zero data");

    // A duplicate refusal can only follow a hit in the set.
    a_dup_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == hnsf_pkg::KIND_INSERT)
            && (m_axis_tdata[1:0] == hnsf_pkg::STAT_DUP) |-> m_axis_tdata[2])
        else $error("duplicate status without found");

    a_query_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == hnsf_pkg::KIND_QUERY)
            |-> m_axis_tdata[1:0] == hnsf_pkg::STAT_OK)
        else $error("query reply with non-zero status");

endmodule

bind hashed_name_set_filter_core hnsf_checker u_hnsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== dv/hnsf_checker.sv =====
`timescale 1ns / 1ps

module hnsf_scoreboard
    import hnsf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [CHAR_W-1:0]     i_s_tdata,
    input  wire logic [CODE_W-1:0]     i_s_tuser,
    input  wire logic                  i_s_tlast,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic [CODE_W-1:0]     i_m_tuser,
    output int                         o_errors,
    output int                         o_pending
);

    typedef struct {
        t_kind              kind;
        t_status            status;
        logic               found;
        logic               filtered;
        logic [HASH_W-1:0]  name_hash;
    } t_name_reply;

    t_name_reply        due_replies[$];
    logic [HASH_W-1:0]  name_hash_acc;
    logic [HASH_W-1:0]  stored_hashes [TABLE_DEPTH];
    int                 stored_count;
    logic               exclude_names;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string field, input logic [HASH_W-1:0] got,
                                   input logic [HASH_W-1:0] want);
        $display("%0t ns: reply %s is %0h, expected %0h", $time, field, got, want);
        o_errors++;
    endtask

    // Folds one character into the running djb2 hash and, at a name end, works
    // out the insert or query reply against the current set; clear empties it.
    task automatic predict_beat(input logic [CODE_W-1:0] act, input logic [CHAR_W-1:0] ch,
                                input logic last_flag);
        t_name_reply        r;
        logic [HASH_W-1:0]  ch_wide;
        logic [HASH_W-1:0]  h;
        logic               present;
        ch_wide = {{(HASH_W - CHAR_W){1'b0}}, ch};
        case (act)
            ACT_CLEAR: begin
                stored_count  = 0;
                name_hash_acc = HASH_SEED;
                r.kind        = KIND_CLEAR;
                r.status      = STAT_OK;
                r.found       = 1'b0;
                r.filtered    = 1'b0;
                r.name_hash   = '0;
                due_replies.push_back(r);
            end
            ACT_INSERT, ACT_QUERY: begin
                h = (name_hash_acc << HASH_SHIFT) + name_hash_acc + ch_wide;
                if (!last_flag) begin
                    name_hash_acc = h;
                end else begin
                    name_hash_acc = HASH_SEED;
                    present = 1'b0;
                    for (int i = 0; i < stored_count; i++) begin
                        if (stored_hashes[i] == h) present = 1'b1;
                    end
                    r.found     = present;
                    r.name_hash = h;
                    if (act == ACT_INSERT) begin
                        r.kind     = KIND_INSERT;
                        r.filtered = 1'b0;
                        // Capacity is checked ahead of the duplicate test.
                        if (stored_count >= TABLE_DEPTH) begin
                            r.status = STAT_FULL;
                        end else if (present) begin
                            r.status = STAT_DUP;
                        end else begin
                            stored_hashes[stored_count] = h;
                            stored_count++;
                            r.status = STAT_OK;
                        end
                    end else begin
                        r.kind     = KIND_QUERY;
                        r.status   = STAT_OK;
                        r.filtered = (present == exclude_names);
                    end
                    due_replies.push_back(r);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_reply(input logic [CODE_W-1:0] kind_bits,
                               input logic [OUT_DATA_W-1:0] data);
        t_name_reply want;
        if (due_replies.size() == 0) begin
            report_mismatch("with nothing outstanding, kind", HASH_W'(kind_bits), '0);
            return;
        end
        want = due_replies.pop_front();
        if (kind_bits !== want.kind)
            report_mismatch("kind", HASH_W'(kind_bits), HASH_W'(want.kind));
        if (data[1:0] !== want.status)
            report_mismatch("status", HASH_W'(data[1:0]), HASH_W'(want.status));
        if (data[2] !== want.found)
            report_mismatch("found", HASH_W'(data[2]), HASH_W'(want.found));
        if (data[3] !== want.filtered)
            report_mismatch("filtered", HASH_W'(data[3]), HASH_W'(want.filtered));
        if (data[HASH_W+3:4] !== want.name_hash)
            report_mismatch("name_hash", data[HASH_W+3:4], want.name_hash);
        if (data[OUT_DATA_W-1:HASH_W+4] !== '0)
            report_mismatch("padding", HASH_W'(data[OUT_DATA_W-1:HASH_W+4]), '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            name_hash_acc = HASH_SEED;
            stored_count  = 0;
            exclude_names = 1'b0;
            due_replies.delete();
        end else begin
            if (i_cfg_we) exclude_names = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) predict_beat(i_s_tuser, i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_reply(i_m_tuser, i_m_tdata);
        end
        o_pending = due_replies.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hnsf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = TABLE_DEPTH_DEF + 8;
    localparam int          POOL_NAMES     = 12;
    localparam int          PHASE_BEATS    = 25;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_wdata;
    logic                   s_axis_tvalid;
    wire logic              s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata;
    logic [CODE_W-1:0]      s_axis_tuser;
    logic                   s_axis_tlast;
    wire logic              m_axis_tvalid;
    logic                   m_axis_tready;
    wire logic [OUT_DATA_W-1:0] m_axis_tdata;
    wire logic [CODE_W-1:0] m_axis_tuser;

    int                     chk_errors;
    int                     chk_pending;
    int                     quiet_cycles;
    bit                     sender_idles;
    bit                     receiver_idles;

    logic [CHAR_W-1:0]      pool_chars [POOL_NAMES][8];
    int                     pool_len [POOL_NAMES];

    hashed_name_set_filter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hnsf_scoreboard u_scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure in bursts of random length.
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
            end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 17);
            end
            m_axis_tready = (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called and returns at a falling edge; valid stays high between beats
    // unless a gap is inserted.
    task automatic send_beat(input logic [CODE_W-1:0] act, input logic [CHAR_W-1:0] ch,
                             input logic last_flag);
        if (sender_idles && $urandom_range(0, 6) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = ch;
        s_axis_tlast  = last_flag;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_pool_name(input int idx, input logic [CODE_W-1:0] act);
        for (int i = 0; i < pool_len[idx]; i++)
            send_beat(act, pool_chars[idx][i], i == pool_len[idx] - 1);
    endtask

    // Holds off the sender until every reply is back and any trailing
    // character has been absorbed.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic excl);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = excl;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        int pick;
        logic [CODE_W-1:0] act;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_INSERT;
        s_axis_tlast   = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        quiet_cycles   = 0;
        for (int n = 0; n < POOL_NAMES; n++) begin
            pool_len[n] = $urandom_range(1, 6);
            for (int i = 0; i < 8; i++) pool_chars[n][i] = CHAR_W'($urandom_range(1, 255));
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, exclude mode first.
        write_mode(1'b1);
        send_beat(ACT_QUERY, 8'h61, 1'b1);
        send_beat(ACT_INSERT, 8'h01, 1'b0);
        send_beat(ACT_INSERT, 8'hFF, 1'b1);
        send_beat(ACT_INSERT, 8'h01, 1'b0);
        send_beat(ACT_INSERT, 8'hFF, 1'b1);
        send_beat(ACT_QUERY, 8'h01, 1'b0);
        send_beat(ACT_QUERY, 8'hFF, 1'b1);
        send_beat(ACT_INSERT, 8'h00, 1'b0);
        send_beat(ACT_INSERT, 8'h80, 1'b1);
        // A name begun as a query but ended as an insert.
        send_beat(ACT_QUERY, 8'h41, 1'b0);
        send_beat(ACT_INSERT, 8'h42, 1'b1);
        send_beat(ACT_INSERT, 8'h10, 1'b0);
        send_beat(ACT_UNUSED, 8'hAA, 1'b1);
        send_beat(ACT_INSERT, 8'h20, 1'b1);
        // A clear drops the name in progress as well as the set.
        send_beat(ACT_INSERT, 8'h33, 1'b0);
        send_beat(ACT_CLEAR, 8'h55, 1'b1);
        send_beat(ACT_QUERY, 8'h61, 1'b1);
        for (int i = 0; i < 9; i++) send_beat(ACT_INSERT, 8'hFF, i == 8);

        write_mode(1'b0);
        send_beat(ACT_QUERY, 8'h01, 1'b0);
        send_beat(ACT_QUERY, 8'hFF, 1'b1);
        for (int i = 0; i < 9; i++) send_beat(ACT_QUERY, 8'hFF, i == 8);

        // Fill the set to capacity with every one-character name.
        send_beat(ACT_CLEAR, 8'h00, 1'b0);
        for (int c = 0; c < TABLE_DEPTH_DEF; c++) send_beat(ACT_INSERT, c[CHAR_W-1:0], 1'b1);
        send_beat(ACT_INSERT, 8'h01, 1'b0);
        send_beat(ACT_INSERT, 8'h02, 1'b1);
        send_beat(ACT_INSERT, 8'h05, 1'b1);
        send_beat(ACT_QUERY, 8'h07, 1'b1);
        send_beat(ACT_CLEAR, 8'hFF, 1'b1);

        // Random phases; the last one runs without idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
            if (phase == 3) begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            sent = 0;
            while (sent < PHASE_BEATS) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_beat(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end else if (pick == 1) begin
                    send_beat(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                    sent++;
                end else if (pick <= 3) begin
                    // Noise: random bytes with actions mixed inside one name.
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        send_beat($urandom_range(0, 1) ? ACT_QUERY : ACT_INSERT,
                                  CHAR_W'($urandom_range(0, 255)), i == len - 1);
                    sent += len;
                end else begin
                    pick = $urandom_range(0, POOL_NAMES - 1);
                    act  = ($urandom_range(0, 4) < 2) ? ACT_INSERT : ACT_QUERY;
                    send_pool_name(pick, act);
                    sent += pool_len[pick];
                end
            end
        end

        s_axis_tvalid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
